// ===== rtl/ilpv_pkg.sv =====
// Package for the integer list parser: commands, status codes, queue item
// and back-end state types, and shared sizing constants. No dependencies.
package ilpv_pkg;

  // Table size and derived widths.
  localparam int MAX_VALUES  = 512;
  localparam int ADDR_W      = $clog2(MAX_VALUES);
  localparam int CNT_W       = $clog2(MAX_VALUES + 1);
  localparam int COUNT_OUT_W = 10;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // Character codes and magnitude limits.
  localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
  localparam logic [31:0] MAG_SAT    = 32'h8000_0001;

  typedef enum logic [1:0] {
    CMD_CHAR     = 2'd0,
    CMD_END_ARG  = 2'd1,
    CMD_END_LIST = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SYNTAX = 3'd1,
    ST_RANGE  = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ARG  = 1'b0,
    KIND_LIST = 1'b1
  } kind_t;

  // One closed argument or end of list, as classified by the front.
  typedef struct packed {
    kind_t       kind;
    status_t     pre_status;
    logic [31:0] value;
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SCAN = 2'd1,
    B_DONE = 2'd2
  } back_state_t;

endpackage

// ===== rtl/ilpv_if.sv =====
// Handshake interfaces for the request and report channels.
// Depends on nothing; payload widths follow the channel field list.
interface ilpv_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] ch;

  modport source (output valid, output command, output ch, input ready);
  modport sink (input valid, input command, input ch, output ready);
endinterface

interface ilpv_rpt_if;
  logic        valid;
  logic        ready;
  logic        verdict_kind;
  logic [31:0] arg_value;
  logic [2:0]  status;
  logic [9:0]  arg_count;

  modport source (output valid, output verdict_kind, output arg_value, output status,
                  output arg_count, input ready);
  modport sink (input valid, input verdict_kind, input arg_value, input status,
                input arg_count, output ready);
endinterface

// ===== rtl/ilpv_front.sv =====
// Front end: accepts request transfers, parses characters one per cycle while the
// queue is not full and classifies each closed argument. Depends on ilpv_pkg and ilpv_if.
module ilpv_front
  import ilpv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  ilpv_req_if.sink       req,
  input  logic           full,
  output logic           push,
  output op_t            push_op
);

  logic [31:0] magnitude_acc;
  logic        overflow_flag;
  logic        negative_flag;
  logic        first_char_flag;
  logic        digit_seen;
  logic        syntax_bad;

  logic        accept;
  logic        is_sign;
  logic        is_digit;
  logic [35:0] grown;
  logic [31:0] signed_value;
  status_t     arg_status;

  // Closing commands need a queue slot; every command stalls while the queue is full.
  assign req.ready = !full;
  assign accept    = req.valid && !full;

  // Character classification and the times-ten accumulate step.
  always_comb begin
    is_sign  = first_char_flag && (req.ch == CHAR_PLUS || req.ch == CHAR_MINUS);
    is_digit = req.ch inside {[CHAR_ZERO:CHAR_NINE]};
    grown    = ({4'd0, magnitude_acc} << 3) + ({4'd0, magnitude_acc} << 1)
               + {32'd0, 4'(req.ch - CHAR_ZERO)};
  end

  // Classification of the argument being closed.
  always_comb begin
    signed_value = negative_flag ? (32'd0 - magnitude_acc) : magnitude_acc;
    if (syntax_bad || !digit_seen) begin
      arg_status = ST_SYNTAX;
    end else if (overflow_flag || magnitude_acc > MAG_LIMIT ||
                 (!negative_flag && magnitude_acc == MAG_LIMIT)) begin
      arg_status = ST_RANGE;
    end else begin
      arg_status = ST_OK;
    end
  end

  // Queue item for an end of argument or end of list.
  always_comb begin
    push               = accept && (req.command == CMD_END_ARG || req.command == CMD_END_LIST);
    push_op.kind       = (req.command == CMD_END_LIST) ? KIND_LIST : KIND_ARG;
    push_op.pre_status = arg_status;
    push_op.value      = signed_value;
  end

  // Argument state; closing an argument or the list clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_acc   <= 32'd0;
      overflow_flag   <= 1'b0;
      negative_flag   <= 1'b0;
      first_char_flag <= 1'b1;
      digit_seen      <= 1'b0;
      syntax_bad      <= 1'b0;
    end else if (accept) begin
      case (req.command)
        CMD_CHAR: begin
          if (is_sign) begin
            negative_flag <= (req.ch == CHAR_MINUS);
          end else if (is_digit) begin
            digit_seen <= 1'b1;
            if (grown > {4'd0, MAG_LIMIT}) begin
              overflow_flag <= 1'b1;
              magnitude_acc <= MAG_SAT;
            end else begin
              magnitude_acc <= grown[31:0];
            end
          end else begin
            syntax_bad <= 1'b1;
          end
          first_char_flag <= 1'b0;
        end
        CMD_END_ARG, CMD_END_LIST: begin
          magnitude_acc   <= 32'd0;
          overflow_flag   <= 1'b0;
          negative_flag   <= 1'b0;
          first_char_flag <= 1'b1;
          digit_seen      <= 1'b0;
          syntax_bad      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // A saturated magnitude always carries the overflow flag.
  a_sat_flagged: assert property (@(posedge clk) disable iff (rst)
    (magnitude_acc > MAG_LIMIT) |-> overflow_flag)
    else $error("magnitude above limit without overflow flag");

endmodule

// ===== rtl/ilpv_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on ilpv_pkg for the item type and depth.
module ilpv_queue
  import ilpv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output op_t  q_op
);

  op_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  assign full    = (fill == QFILL_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_op    = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue read while empty");

endmodule

// ===== rtl/ilpv_back.sv =====
// Back end: duplicate scan over the value table, table store, list status
// and the report output register. Depends on ilpv_pkg and ilpv_if.
module ilpv_back
  import ilpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        pop,
  ilpv_rpt_if.source  rpt
);

  back_state_t state;
  back_state_t state_next;

  // Value table, read one entry per cycle during a scan.
  logic [31:0] seen_values [MAX_VALUES];
  logic [31:0] mem_q;

  logic [CNT_W-1:0] value_count;
  status_t          list_status;
  logic [CNT_W-1:0] idx;
  logic             issuing;
  logic             cmp_pend;
  logic             dup;
  logic [31:0]      cur_value;

  logic             out_valid;
  kind_t            out_kind;
  logic [31:0]      out_value;
  status_t          out_status;
  logic [CNT_W-1:0] out_count;

  logic             out_free;
  logic             emit;
  kind_t            emit_kind;
  logic [31:0]      emit_value;
  status_t          emit_status;
  logic [CNT_W-1:0] emit_count;
  logic             start_scan;
  logic             store;
  logic             clear_list;

  assign out_free         = !out_valid || rpt.ready;
  assign rpt.valid        = out_valid;
  assign rpt.verdict_kind = out_kind;
  assign rpt.arg_value    = out_value;
  assign rpt.status       = out_status;
  assign rpt.arg_count    = COUNT_OUT_W'(out_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control for each queue item.
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_ARG;
    emit_value  = 32'd0;
    emit_status = ST_OK;
    emit_count  = value_count;
    start_scan  = 1'b0;
    store       = 1'b0;
    clear_list  = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_op.kind == KIND_LIST) begin
            if (out_free) begin
              pop         = 1'b1;
              emit        = 1'b1;
              emit_kind   = KIND_LIST;
              emit_status = list_status;
              clear_list  = 1'b1;
            end
          end else if (q_op.pre_status != ST_OK) begin
            if (out_free) begin
              pop         = 1'b1;
              emit        = 1'b1;
              emit_status = q_op.pre_status;
            end
          end else begin
            pop        = 1'b1;
            start_scan = 1'b1;
            state_next = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (!issuing && !cmp_pend) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = B_IDLE;
          if (dup) begin
            emit_status = ST_DUP;
          end else if (value_count >= CNT_W'(MAX_VALUES)) begin
            emit_status = ST_FULL;
          end else begin
            store      = 1'b1;
            emit_value = cur_value;
            emit_count = value_count + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Table write and registered table read.
  always_ff @(posedge clk) begin
    if (store) begin
      seen_values[value_count[ADDR_W-1:0]] <= cur_value;
    end
    mem_q <= seen_values[idx[ADDR_W-1:0]];
  end

  // Scan pointer, compare pipeline and the value under test.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      cmp_pend <= 1'b0;
      dup      <= 1'b0;
    end else if (start_scan) begin
      issuing  <= (value_count != '0);
      cmp_pend <= 1'b0;
      dup      <= 1'b0;
    end else if (state == B_SCAN) begin
      cmp_pend <= issuing;
      if (issuing && (idx + CNT_W'(1)) == value_count) begin
        issuing <= 1'b0;
      end
      if (cmp_pend && mem_q == cur_value) begin
        dup <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      idx       <= '0;
      cur_value <= q_op.value;
    end else if (state == B_SCAN && issuing) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // List count and first error of the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      list_status <= ST_OK;
    end else if (clear_list) begin
      value_count <= '0;
      list_status <= ST_OK;
    end else begin
      if (store) begin
        value_count <= value_count + CNT_W'(1);
      end
      if (emit && emit_status != ST_OK && list_status == ST_OK) begin
        list_status <= emit_status;
      end
    end
  end

  // Report output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rpt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_value  <= emit_value;
      out_status <= emit_status;
      out_count  <= emit_count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    value_count <= CNT_W'(MAX_VALUES))
    else $error("value count beyond table size");
  a_list_clears: assert property (@(posedge clk) disable iff (rst)
    clear_list |=> (value_count == '0 && list_status == ST_OK))
    else $error("list state not cleared after verdict");
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN && issuing) |-> idx < value_count)
    else $error("table read beyond stored values");

endmodule

// ===== rtl/int_list_parse_validate.sv =====
// Top level of the signed decimal list parser with duplicate check.
// Depends on ilpv_pkg, ilpv_if, ilpv_front, ilpv_queue and ilpv_back.
//
//   channel  role    payload
//   req      sink    command[1:0], ch[7:0]
//   rpt      source  verdict_kind, arg_value[31:0], status[2:0], arg_count[9:0]
//
// A character transfer updates the front end state directly; closing commands are queued.
// An argument that passes the syntax and range checks is compared in the back
// end against the n values stored so far in the list, walking the single
// table read port one entry per cycle.
// Reset is synchronous; the table needs no clearing pass.
// The request side stalls only when the four-entry queue is full.
module int_list_parse_validate
  import ilpv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ilpv_req_if.sink   req,
  ilpv_rpt_if.source rpt
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  logic q_valid;
  op_t  q_op;

  ilpv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .full    (full),
    .push    (push),
    .push_op (push_op)
  );

  ilpv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  ilpv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .rpt     (rpt)
  );

endmodule
